// ===== sv/hrwa_pkg.sv =====
`default_nettype none

package hrwa_pkg;

   // field widths
   localparam int IR_W       = 18;
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 8;
   localparam int INTERVAL_W = 16;
   localparam int CONTACT_W  = 18;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTACT      = 2'd3;

   // register reset values
   localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 16'd300;
   localparam logic [RATE_W-1:0]     MIN_RATE_RST     = 8'd30;
   localparam logic [RATE_W-1:0]     MAX_RATE_RST     = 8'd180;
   localparam logic [CONTACT_W-1:0]  CONTACT_RST      = 18'd20000;

   // divider and rate test
   localparam int DIV_W  = 16;
   localparam int DVSR_W = 32;
   localparam int PROD_W = TIME_W + RATE_W;

   localparam logic [DIV_W-1:0] MS_PER_MINUTE = 16'd60000;

   // controller to datapath
   typedef struct packed {
      logic load_in;
      logic calc_delta;
      logic calc_prod;
      logic take_beat;
      logic div_start_bpm;
      logic win_write;
      logic sum_run;
      logic div_start_avg;
      logic set_rate;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic gap_ok;
      logic rate_ok;
      logic div_done;
      logic sum_done;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/hrwa_req_if.sv =====
`default_nettype none

interface hrwa_req_if;
   logic                          valid;
   logic                          ready;
   logic [hrwa_pkg::IR_W-1:0]     ir_sample;
   logic                          beat_flag;
   logic [hrwa_pkg::TIME_W-1:0]   time_ms;

   modport source (output valid, output ir_sample, output beat_flag, output time_ms,
                   input ready);
   modport sink   (input valid, input ir_sample, input beat_flag, input time_ms,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/hrwa_rsp_if.sv =====
`default_nettype none

interface hrwa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hrwa_pkg::RATE_W-1:0]   heart_rate;
   logic                          beat_accepted;
   logic                          finger_present;

   modport source (output valid, output heart_rate, output beat_accepted,
                   output finger_present, input ready);
   modport sink   (input valid, input heart_rate, input beat_accepted,
                   input finger_present, output ready);
endinterface

`default_nettype wire

// ===== sv/hrwa_div.sv =====
`default_nettype none

module hrwa_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [hrwa_pkg::DIV_W-1:0]  dividend,
   input  wire logic [hrwa_pkg::DVSR_W-1:0] divisor,
   output logic      [hrwa_pkg::DIV_W-1:0]  quotient,
   output logic                             done
);

   localparam int DIV_W  = hrwa_pkg::DIV_W;
   localparam int DVSR_W = hrwa_pkg::DVSR_W;
   localparam int STEP_W = $clog2(DIV_W);

   logic [DIV_W-1:0]  qd_ff, qd_in;
   logic [DVSR_W-1:0] dvsr_ff;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DVSR_W:0]   rem_shift;
   logic              fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, qd_ff[DIV_W-1]};
      fits      = rem_shift >= {1'b0, dvsr_ff};
      if (fits) begin
         rem_in = DVSR_W'(rem_shift - {1'b0, dvsr_ff});
      end else begin
         rem_in = rem_shift[DVSR_W-1:0];
      end
      qd_in = {qd_ff[DIV_W-2:0], fits};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands
   always_ff @(posedge clock) begin
      if (start) begin
         qd_ff   <= dividend;
         dvsr_ff <= divisor;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         qd_ff  <= qd_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = qd_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== sv/hrwa_datapath.sv =====
`default_nettype none

module hrwa_datapath #(
   parameter int WINDOW_DEPTH = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [hrwa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hrwa_pkg::CSR_DATA_W-1:0] csr_wdata,
   // input item
   input  wire logic [hrwa_pkg::IR_W-1:0]       ir_sample,
   input  wire logic                            beat_flag,
   input  wire logic [hrwa_pkg::TIME_W-1:0]     time_ms,
   // controller
   input  wire hrwa_pkg::dp_cmd_type            cmd,
   output hrwa_pkg::dp_status_type              status,
   // result item
   output logic      [hrwa_pkg::RATE_W-1:0]     heart_rate,
   output logic                                 beat_accepted,
   output logic                                 finger_present
);

   localparam int RATE_W = hrwa_pkg::RATE_W;
   localparam int TIME_W = hrwa_pkg::TIME_W;
   localparam int PROD_W = hrwa_pkg::PROD_W;
   localparam int DIV_W  = hrwa_pkg::DIV_W;
   localparam int DVSR_W = hrwa_pkg::DVSR_W;
   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = $clog2(WINDOW_DEPTH * 255 + 1);

   // configuration registers
   logic [hrwa_pkg::INTERVAL_W-1:0] min_int_ff;
   logic [RATE_W-1:0]               min_rate_ff;
   logic [RATE_W-1:0]               max_rate_ff;
   logic [hrwa_pkg::CONTACT_W-1:0]  contact_ff;

   // captured item
   logic [hrwa_pkg::IR_W-1:0] ir_ff;
   logic                      beat_ff;
   logic [TIME_W-1:0]         now_ff;

   // interval and rate test
   logic [TIME_W-1:0] last_beat_ff;
   logic [TIME_W-1:0] delta_ff;
   logic              finger_ff;
   logic              gap_ok_ff;
   logic [PROD_W-1:0] lo_prod_ff;
   logic [PROD_W-1:0] hi_prod_ff;

   // window state
   logic [RATE_W-1:0] window_mem [WINDOW_DEPTH];
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RATE_W-1:0] rate_ff;
   logic              accepted_ff;

   // summing pass
   logic [CNT_W-1:0]  ptr_ff;
   logic [RATE_W-1:0] rd_data_ff;
   logic              rd_vld_ff;
   logic [SUM_W-1:0]  sum_ff;

   // result registers
   logic [RATE_W-1:0] out_rate_ff;
   logic              out_accepted_ff;
   logic              out_finger_ff;

   // shared divider
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DVSR_W-1:0] div_divisor;
   logic [DIV_W-1:0]  div_quotient;
   logic              div_done;

   logic [SLOT_W-1:0] slot_in;
   logic [CNT_W-1:0]  cnt_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_int_ff  <= hrwa_pkg::MIN_INTERVAL_RST;
         min_rate_ff <= hrwa_pkg::MIN_RATE_RST;
         max_rate_ff <= hrwa_pkg::MAX_RATE_RST;
         contact_ff  <= hrwa_pkg::CONTACT_RST;
      end else if (csr_we) begin
         case (csr_index)
            hrwa_pkg::CSR_MIN_INTERVAL: min_int_ff  <= csr_wdata[hrwa_pkg::INTERVAL_W-1:0];
            hrwa_pkg::CSR_MIN_RATE:     min_rate_ff <= csr_wdata[RATE_W-1:0];
            hrwa_pkg::CSR_MAX_RATE:     max_rate_ff <= csr_wdata[RATE_W-1:0];
            hrwa_pkg::CSR_CONTACT:      contact_ff  <= csr_wdata[hrwa_pkg::CONTACT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // item capture, interval and the two rate-limit products
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ir_ff   <= ir_sample;
         beat_ff <= beat_flag;
         now_ff  <= time_ms;
      end
      if (cmd.calc_delta) begin
         delta_ff  <= now_ff - last_beat_ff;
         finger_ff <= ir_ff > contact_ff;
      end
      if (cmd.calc_prod) begin
         gap_ok_ff  <= beat_ff && (delta_ff >= TIME_W'(min_int_ff));
         lo_prod_ff <= PROD_W'(min_rate_ff) * PROD_W'(delta_ff);
         hi_prod_ff <= PROD_W'(max_rate_ff) * PROD_W'(delta_ff);
      end
   end

   assign status.gap_ok  = gap_ok_ff;
   assign status.rate_ok = (lo_prod_ff <= PROD_W'(hrwa_pkg::MS_PER_MINUTE)) &&
                           (hi_prod_ff >= PROD_W'(hrwa_pkg::MS_PER_MINUTE));

   // divider operand selection: 60000 / interval, then sum / count
   assign div_start    = cmd.div_start_bpm || cmd.div_start_avg;
   assign div_dividend = cmd.div_start_avg ? DIV_W'(sum_ff) : hrwa_pkg::MS_PER_MINUTE;
   assign div_divisor  = cmd.div_start_avg ? DVSR_W'(cnt_ff) : delta_ff;

   hrwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   assign status.div_done = div_done;

   // ring pointer wrap and saturating count
   always_comb begin
      if (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
      if (cnt_ff == CNT_W'(WINDOW_DEPTH)) begin
         cnt_in = cnt_ff;
      end else begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // window and rate state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_beat_ff <= '0;
         slot_ff      <= '0;
         cnt_ff       <= '0;
         rate_ff      <= '0;
      end else begin
         if (cmd.take_beat) begin
            last_beat_ff <= now_ff;
         end
         if (cmd.win_write) begin
            slot_ff <= slot_in;
            cnt_ff  <= cnt_in;
         end
         if (cmd.set_rate) begin
            rate_ff <= div_quotient[RATE_W-1:0];
         end
         if (cmd.commit && !finger_ff) begin
            slot_ff <= '0;
            cnt_ff  <= '0;
            rate_ff <= '0;
         end
      end
   end

   // window memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.win_write) begin
         window_mem[slot_ff] <= div_quotient[RATE_W-1:0];
      end
      if (cmd.sum_run && (ptr_ff != cnt_ff)) begin
         rd_data_ff <= window_mem[ptr_ff[SLOT_W-1:0]];
      end
   end

   // summing pass over the valid slots
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         ptr_ff    <= '0;
      end else if (cmd.win_write) begin
         rd_vld_ff <= 1'b0;
         ptr_ff    <= '0;
      end else if (cmd.sum_run) begin
         rd_vld_ff <= ptr_ff != cnt_ff;
         if (ptr_ff != cnt_ff) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_write) begin
         sum_ff <= '0;
      end else if (cmd.sum_run && rd_vld_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
      end
   end

   assign status.sum_done = (ptr_ff == cnt_ff) && !rd_vld_ff;

   // beat accepted flag for this item
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         accepted_ff <= 1'b0;
      end else if (cmd.win_write) begin
         accepted_ff <= 1'b1;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_rate_ff     <= finger_ff ? rate_ff : '0;
         out_accepted_ff <= accepted_ff;
         out_finger_ff   <= finger_ff;
      end
   end

   assign heart_rate     = out_rate_ff;
   assign beat_accepted  = out_accepted_ff;
   assign finger_present = out_finger_ff;

endmodule

`default_nettype wire

// ===== sv/hrwa_ctrl.sv =====
`default_nettype none

module hrwa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire hrwa_pkg::dp_status_type status,
   output hrwa_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DELTA   = 3'd1;
   localparam logic [2:0] ST_MUL     = 3'd2;
   localparam logic [2:0] ST_TEST    = 3'd3;
   localparam logic [2:0] ST_DIV_BPM = 3'd4;
   localparam logic [2:0] ST_SUM     = 3'd5;
   localparam logic [2:0] ST_DIV_AVG = 3'd6;
   localparam logic [2:0] ST_FINISH  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // sequencing of one item
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.calc_delta = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.calc_prod = 1'b1;
            state_in      = ST_TEST;
         end
         ST_TEST: begin
            state_in = ST_FINISH;
            if (status.gap_ok) begin
               cmd.take_beat = 1'b1;
               if (status.rate_ok) begin
                  cmd.div_start_bpm = 1'b1;
                  state_in          = ST_DIV_BPM;
               end
            end
         end
         ST_DIV_BPM: begin
            if (status.div_done) begin
               cmd.win_write = 1'b1;
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            if (status.sum_done) begin
               cmd.div_start_avg = 1'b1;
               state_in          = ST_DIV_AVG;
            end else begin
               cmd.sum_run = 1'b1;
            end
         end
         ST_DIV_AVG: begin
            if (status.div_done) begin
               cmd.set_rate = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the result register to free up
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/heart_rate_window_averager.sv =====
// Heart-rate window averager.
// req_chan carries one IR sample per item with the beat flag of an external
// detector and a millisecond timestamp; rsp_chan returns exactly one item per
// sample: the averaged rate, whether this beat entered the window, and the
// finger-contact flag. Both channels move an item when valid and ready are
// high at a rising clock edge. The csr_ port writes the four limit registers
// by index; write only while the block is idle.
// One item is in work at a time. A sample without an accepted beat steps
// through the delta, multiply and test states to the finish state, which
// commits its result; the block is ready for the next item as that result
// becomes valid. An accepted beat runs two passes of the shared 16-step
// restoring divider (60000 / interval, then sum / count) around a summing
// pass over the window memory, one slot per cycle, before the finish state.
// The window memory has one write port and one registered read port.
// A new item is taken while the last result still waits in the output
// register; if the receiver stalls, the next result is held back until the
// register frees. Synchronous reset clears the rate, the window count, the
// ring pointer and the last beat time and restores the register defaults.
`default_nettype none

module heart_rate_window_averager #(
   parameter int WINDOW_DEPTH = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   hrwa_req_if.sink                             req_chan,
   hrwa_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [hrwa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hrwa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   hrwa_pkg::dp_cmd_type    cmd;
   hrwa_pkg::dp_status_type status;

   logic                        req_ready;
   logic                        rsp_valid;
   logic [hrwa_pkg::RATE_W-1:0] heart_rate;
   logic                        beat_accepted;
   logic                        finger_present;

   // sequencer
   hrwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, window and registers
   hrwa_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .ir_sample      (req_chan.ir_sample),
      .beat_flag      (req_chan.beat_flag),
      .time_ms        (req_chan.time_ms),
      .cmd            (cmd),
      .status         (status),
      .heart_rate     (heart_rate),
      .beat_accepted  (beat_accepted),
      .finger_present (finger_present)
   );

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.heart_rate     = heart_rate;
   assign rsp_chan.beat_accepted  = beat_accepted;
   assign rsp_chan.finger_present = finger_present;

endmodule

`default_nettype wire

// ===== sv/hrwa_checker.sv =====
`default_nettype none

module hrwa_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [hrwa_pkg::RATE_W-1:0] heart_rate,
   input wire logic                        finger_present
);

   // no result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item in work at a time: taking an item closes the input
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after taking an item");

   // lost contact always reports a zero rate
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !finger_present) |-> (heart_rate == '0))
      else $error("nonzero rate without finger contact");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind heart_rate_window_averager hrwa_checker u_hrwa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .heart_rate     (rsp_chan.heart_rate),
   .finger_present (rsp_chan.finger_present)
);

`default_nettype wire
